@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every sampled edge out of reset
`define LSIU_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LSIU_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ hw/rtl/lsiu_pkg.sv @@
`default_nettype none

package lsiu_pkg;

	localparam logic [3:0] OP_AND = 4'd0;
	localparam logic [3:0] OP_EOR = 4'd1;
	localparam logic [3:0] OP_ORA = 4'd2;
	localparam logic [3:0] OP_ASL = 4'd3;
	localparam logic [3:0] OP_LSR = 4'd4;
	localparam logic [3:0] OP_ROL = 4'd5;
	localparam logic [3:0] OP_ROR = 4'd6;
	localparam logic [3:0] OP_SLO = 4'd7;
	localparam logic [3:0] OP_RLA = 4'd8;
	localparam logic [3:0] OP_SRE = 4'd9;
	localparam logic [3:0] OP_SAX = 4'd10;
	localparam logic [3:0] OP_BIT = 4'd11;

	localparam logic [3:0] AM_IMM  = 4'd0;
	localparam logic [3:0] AM_ACC  = 4'd1;
	localparam logic [3:0] AM_ZP   = 4'd2;
	localparam logic [3:0] AM_ZPX  = 4'd3;
	localparam logic [3:0] AM_ZPY  = 4'd4;
	localparam logic [3:0] AM_ABS  = 4'd5;
	localparam logic [3:0] AM_ABSX = 4'd6;
	localparam logic [3:0] AM_ABSY = 4'd7;
	localparam logic [3:0] AM_INDX = 4'd8;
	localparam logic [3:0] AM_INDY = 4'd9;

	typedef struct packed {
		logic [1:0] len;
		logic [3:0] cyc;
	} timing_t;

	typedef struct packed {
		logic [3:0] mode;
		logic [3:0] addressing;
		logic [7:0] operand;
		logic [7:0] x_value;
	} item_t;

	typedef struct packed {
		logic [7:0] acc;
		logic       neg;
		logic       zero;
		logic       carry;
		logic       ovf;
	} arch_t;

	typedef struct packed {
		logic       handled;
		logic       write_enable;
		logic [7:0] write_value;
		logic [1:0] instr_length;
		logic [3:0] cycle_count;
	} result_t;

	function automatic timing_t tm(input logic [1:0] len, input logic [3:0] cyc);
		timing_t t;
		t.len = len;
		t.cyc = cyc;
		return t;
	endfunction

	// length and cycle count per combination, zero when not handled
	function automatic timing_t timing_lookup(input logic [3:0] mode, input logic [3:0] am);
		timing_t t;
		t = tm(2'd0, 4'd0);
		unique case (mode) inside
			OP_AND, OP_EOR, OP_ORA: begin
				unique case (am)
					AM_IMM:  t = tm(2'd2, 4'd2);
					AM_ZP:   t = tm(2'd2, 4'd3);
					AM_ZPX:  t = tm(2'd2, 4'd4);
					AM_ABS:  t = tm(2'd3, 4'd4);
					AM_ABSX: t = tm(2'd3, 4'd4);
					AM_ABSY: t = tm(2'd3, 4'd4);
					AM_INDX: t = tm(2'd2, 4'd6);
					AM_INDY: t = tm(2'd2, 4'd5);
					default: t = tm(2'd0, 4'd0);
				endcase
			end
			OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				unique case (am)
					AM_ACC:  t = tm(2'd1, 4'd2);
					AM_ZP:   t = tm(2'd2, 4'd5);
					AM_ZPX:  t = tm(2'd2, 4'd6);
					AM_ABS:  t = tm(2'd3, 4'd6);
					AM_ABSX: t = tm(2'd3, 4'd7);
					default: t = tm(2'd0, 4'd0);
				endcase
			end
			OP_SLO, OP_RLA, OP_SRE: begin
				unique case (am)
					AM_ZP:   t = tm(2'd2, 4'd5);
					AM_ZPX:  t = tm(2'd2, 4'd6);
					AM_ABS:  t = tm(2'd3, 4'd6);
					AM_ABSX: t = tm(2'd3, 4'd7);
					AM_ABSY: t = tm(2'd3, 4'd7);
					AM_INDX: t = tm(2'd2, 4'd8);
					AM_INDY: t = tm(2'd2, 4'd8);
					default: t = tm(2'd0, 4'd0);
				endcase
			end
			OP_SAX: begin
				unique case (am)
					AM_ZP:   t = tm(2'd2, 4'd3);
					AM_ZPY:  t = tm(2'd2, 4'd4);
					AM_ABS:  t = tm(2'd3, 4'd4);
					AM_INDX: t = tm(2'd2, 4'd6);
					default: t = tm(2'd0, 4'd0);
				endcase
			end
			OP_BIT: begin
				unique case (am)
					AM_ZP:   t = tm(2'd2, 4'd3);
					AM_ABS:  t = tm(2'd3, 4'd4);
					default: t = tm(2'd0, 4'd0);
				endcase
			end
			default: t = tm(2'd0, 4'd0);
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/logic_shift_instruction_unit.sv @@
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   mode, addressing, operand, x_value
// out      from block out_valid / out_stall handled, write_enable, write_value,
//                                           instr_length, cycle_count, acc_out,
//                                           neg_out, zero_out, carry_out, overflow_out
//
// one item per cycle unless the output stalls; an accepted item goes through the input
// register and the result register; it executes between the two, reading and
// updating the accumulator and flags as it moves into the result register
// reset clears the accumulator, all flags and both valid bits
// a stall at the output holds the result and backs up into in_stall only when the
// input register is also full
`default_nettype none

module logic_shift_instruction_unit (
	input  var logic       clk,
	input  var logic       arst_n,
	input  var logic       in_valid,
	output var logic       in_stall,
	input  var logic [3:0] mode,
	input  var logic [3:0] addressing,
	input  var logic [7:0] operand,
	input  var logic [7:0] x_value,
	output var logic       out_valid,
	input  var logic       out_stall,
	output var logic       handled,
	output var logic       write_enable,
	output var logic [7:0] write_value,
	output var logic [1:0] instr_length,
	output var logic [3:0] cycle_count,
	output var logic [7:0] acc_out,
	output var logic       neg_out,
	output var logic       zero_out,
	output var logic       carry_out,
	output var logic       overflow_out
);

	lsiu_pkg::item_t   item_s1;
	logic              valid_s1;
	lsiu_pkg::arch_t   arch_q;
	lsiu_pkg::arch_t   arch_nxt;
	lsiu_pkg::result_t res_nxt;
	lsiu_pkg::result_t res_s2;
	lsiu_pkg::arch_t   flags_s2;
	logic              valid_s2;
	logic              s2_free;
	logic              adv_s1;
	logic              take_in;

	assign s2_free  = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign take_in  = in_valid && !in_stall;

	lsiu_exec u_exec (
		.item (item_s1),
		.cur  (arch_q),
		.nxt  (arch_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			arch_q   <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				arch_q   <= arch_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.mode       <= mode;
			item_s1.addressing <= addressing;
			item_s1.operand    <= operand;
			item_s1.x_value    <= x_value;
		end
		if (adv_s1) begin
			res_s2   <= res_nxt;
			flags_s2 <= arch_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign handled      = res_s2.handled;
	assign write_enable = res_s2.write_enable;
	assign write_value  = res_s2.write_value;
	assign instr_length = res_s2.instr_length;
	assign cycle_count  = res_s2.cycle_count;
	assign acc_out      = flags_s2.acc;
	assign neg_out      = flags_s2.neg;
	assign zero_out     = flags_s2.zero;
	assign carry_out    = flags_s2.carry;
	assign overflow_out = flags_s2.ovf;

endmodule

`default_nettype wire

@@ hw/rtl/lsiu_exec.sv @@
`default_nettype none

module lsiu_exec (
	input  var lsiu_pkg::item_t   item,
	input  var lsiu_pkg::arch_t   cur,
	output var lsiu_pkg::arch_t   nxt,
	output var lsiu_pkg::result_t res
);

	lsiu_pkg::timing_t t;
	logic              hit;
	logic              go_left;
	logic              rotate;
	logic [7:0]        src;
	logic [7:0]        sh;
	logic              sh_c;
	logic [7:0]        acc_n;

	always_comb begin
		t   = lsiu_pkg::timing_lookup(item.mode, item.addressing);
		hit = (t.cyc != 4'd0);

		// shared shifter
		src = (item.addressing == lsiu_pkg::AM_ACC) ? cur.acc : item.operand;
		case (item.mode) inside
			lsiu_pkg::OP_ASL, lsiu_pkg::OP_ROL, lsiu_pkg::OP_SLO, lsiu_pkg::OP_RLA:
				go_left = 1'b1;
			default:
				go_left = 1'b0;
		endcase
		case (item.mode) inside
			lsiu_pkg::OP_ROL, lsiu_pkg::OP_ROR, lsiu_pkg::OP_RLA:
				rotate = 1'b1;
			default:
				rotate = 1'b0;
		endcase
		if (go_left) begin
			sh   = {src[6:0], rotate & cur.carry};
			sh_c = src[7];
		end else begin
			sh   = {rotate & cur.carry, src[7:1]};
			sh_c = src[0];
		end

		nxt                = cur;
		res.handled        = hit;
		res.write_enable   = 1'b0;
		res.write_value    = 8'd0;
		res.instr_length   = t.len;
		res.cycle_count    = t.cyc;
		acc_n              = cur.acc;

		if (hit) begin
			unique case (item.mode) inside
				lsiu_pkg::OP_AND, lsiu_pkg::OP_EOR, lsiu_pkg::OP_ORA: begin
					if (item.mode == lsiu_pkg::OP_AND) begin
						acc_n = cur.acc & item.operand;
					end else if (item.mode == lsiu_pkg::OP_EOR) begin
						acc_n = cur.acc ^ item.operand;
					end else begin
						acc_n = cur.acc | item.operand;
					end
					nxt.acc  = acc_n;
					nxt.neg  = acc_n[7];
					nxt.zero = (acc_n == 8'd0);
				end
				lsiu_pkg::OP_ASL, lsiu_pkg::OP_LSR, lsiu_pkg::OP_ROL, lsiu_pkg::OP_ROR: begin
					nxt.carry = sh_c;
					nxt.neg   = sh[7];
					nxt.zero  = (sh == 8'd0);
					if (item.addressing == lsiu_pkg::AM_ACC) begin
						nxt.acc = sh;
					end else begin
						res.write_enable = 1'b1;
						res.write_value  = sh;
					end
				end
				lsiu_pkg::OP_SLO, lsiu_pkg::OP_RLA, lsiu_pkg::OP_SRE: begin
					if (item.mode == lsiu_pkg::OP_SLO) begin
						acc_n = cur.acc | sh;
					end else if (item.mode == lsiu_pkg::OP_RLA) begin
						acc_n = cur.acc & sh;
					end else begin
						acc_n = cur.acc ^ sh;
					end
					res.write_enable = 1'b1;
					res.write_value  = sh;
					nxt.carry        = sh_c;
					nxt.acc          = acc_n;
					nxt.neg          = acc_n[7];
					nxt.zero         = (acc_n == 8'd0);
				end
				lsiu_pkg::OP_SAX: begin
					res.write_enable = 1'b1;
					res.write_value  = cur.acc & item.x_value;
				end
				default: begin
					// bit test
					nxt.zero = ((cur.acc & item.operand) == 8'd0);
					nxt.ovf  = item.operand[6];
					nxt.neg  = item.operand[7];
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lsiu_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module lsiu_checker (
	input var logic       clk,
	input var logic       arst_n,
	input var logic       in_stall,
	input var logic       out_valid,
	input var logic       out_stall,
	input var logic       handled,
	input var logic       write_enable,
	input var logic [7:0] write_value,
	input var logic [1:0] instr_length,
	input var logic [3:0] cycle_count,
	input var logic [7:0] acc_out
);

	// unhandled items report no write and no timing
	`LSIU_ASSERT(a_unhandled_zero,
		!out_valid || handled || (!write_enable && write_value == 8'd0 &&
		instr_length == 2'd0 && cycle_count == 4'd0),
		"unhandled item carries nonzero fields")

	// handled items always report a nonzero length and a cycle_count in range
	`LSIU_ASSERT(a_handled_timing,
		!out_valid || !handled || (instr_length != 2'd0 && cycle_count >= 4'd2 &&
		cycle_count <= 4'd8),
		"handled item has bad timing")

	// a memory write is never a one-byte instruction, and its cycle_count is bounded below
	`LSIU_ASSERT(a_write_timing,
		!out_valid || !write_enable || (instr_length >= 2'd2 && cycle_count >= 4'd3),
		"write with implausible timing")

	// a stalled result stays put
	`LSIU_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(acc_out) && $stable(write_value), "stalled result changed")

	// the input only backs up behind a stalled result
	`LSIU_ASSERT(a_in_stall_cause, !in_stall || (out_valid && out_stall),
		"input stalled without a stalled result")

endmodule

bind logic_shift_instruction_unit lsiu_checker u_lsiu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.handled      (handled),
	.write_enable (write_enable),
	.write_value  (write_value),
	.instr_length (instr_length),
	.cycle_count  (cycle_count),
	.acc_out      (acc_out)
);

`default_nettype wire

@@ test/tb_top.sv @@
typedef struct packed {
	logic       handled;
	logic       write_enable;
	logic [7:0] write_value;
	logic [1:0] instr_length;
	logic [3:0] cycle_count;
	logic [7:0] acc;
	logic       neg;
	logic       zero;
	logic       carry;
	logic       ovf;
} exec_result_t;

class exec_predict;
	logic [7:0] acc;
	logic n, z, c, v;
	exec_result_t exec_results[$];
	int mismatches;

	function new();
		acc = 8'h00;
		n = 1'b0;
		z = 1'b0;
		c = 1'b0;
		v = 1'b0;
		mismatches = 0;
	endfunction

	// {length, cycles}, zero when the pairing is not supported
	function logic [5:0] timing(logic [3:0] m, logic [3:0] a);
		logic [5:0] t;
		t = '0;
		case (m) inside
			lsiu_pkg::OP_AND, lsiu_pkg::OP_EOR, lsiu_pkg::OP_ORA: begin
				case (a) inside
					lsiu_pkg::AM_IMM: t = 6'h22;
					lsiu_pkg::AM_ZP: t = 6'h23;
					lsiu_pkg::AM_ZPX: t = 6'h24;
					lsiu_pkg::AM_ABS, lsiu_pkg::AM_ABSX, lsiu_pkg::AM_ABSY: t = 6'h34;
					lsiu_pkg::AM_INDX: t = 6'h26;
					lsiu_pkg::AM_INDY: t = 6'h25;
					default: t = '0;
				endcase
			end
			lsiu_pkg::OP_ASL, lsiu_pkg::OP_LSR, lsiu_pkg::OP_ROL, lsiu_pkg::OP_ROR: begin
				case (a)
					lsiu_pkg::AM_ACC: t = 6'h12;
					lsiu_pkg::AM_ZP: t = 6'h25;
					lsiu_pkg::AM_ZPX: t = 6'h26;
					lsiu_pkg::AM_ABS: t = 6'h36;
					lsiu_pkg::AM_ABSX: t = 6'h37;
					default: t = '0;
				endcase
			end
			lsiu_pkg::OP_SLO, lsiu_pkg::OP_RLA, lsiu_pkg::OP_SRE: begin
				case (a) inside
					lsiu_pkg::AM_ZP: t = 6'h25;
					lsiu_pkg::AM_ZPX: t = 6'h26;
					lsiu_pkg::AM_ABS: t = 6'h36;
					lsiu_pkg::AM_ABSX, lsiu_pkg::AM_ABSY: t = 6'h37;
					lsiu_pkg::AM_INDX, lsiu_pkg::AM_INDY: t = 6'h28;
					default: t = '0;
				endcase
			end
			lsiu_pkg::OP_SAX: begin
				case (a)
					lsiu_pkg::AM_ZP: t = 6'h23;
					lsiu_pkg::AM_ZPY: t = 6'h24;
					lsiu_pkg::AM_ABS: t = 6'h34;
					lsiu_pkg::AM_INDX: t = 6'h26;
					default: t = '0;
				endcase
			end
			lsiu_pkg::OP_BIT: begin
				case (a)
					lsiu_pkg::AM_ZP: t = 6'h23;
					lsiu_pkg::AM_ABS: t = 6'h34;
					default: t = '0;
				endcase
			end
			default: t = '0;
		endcase
		return t;
	endfunction

	function void set_nz(logic [7:0] val);
		n = val[7];
		z = (val == 8'h00);
	endfunction

	function logic [7:0] shift(logic [3:0] kind, logic [7:0] val);
		logic cin;
		logic [7:0] res;
		cin = c;
		case (kind)
			lsiu_pkg::OP_ASL: begin
				c = val[7];
				res = {val[6:0], 1'b0};
			end
			lsiu_pkg::OP_LSR: begin
				c = val[0];
				res = {1'b0, val[7:1]};
			end
			lsiu_pkg::OP_ROL: begin
				c = val[7];
				res = {val[6:0], cin};
			end
			default: begin
				c = val[0];
				res = {cin, val[7:1]};
			end
		endcase
		set_nz(res);
		return res;
	endfunction

	function void issue(logic [3:0] m, logic [3:0] a, logic [7:0] opnd, logic [7:0] xv);
		exec_result_t r;
		logic [5:0] t;
		r = '0;
		t = timing(m, a);
		if (t != '0) begin
			case (m) inside
				lsiu_pkg::OP_AND: begin
					acc = acc & opnd;
					set_nz(acc);
				end
				lsiu_pkg::OP_EOR: begin
					acc = acc ^ opnd;
					set_nz(acc);
				end
				lsiu_pkg::OP_ORA: begin
					acc = acc | opnd;
					set_nz(acc);
				end
				lsiu_pkg::OP_ASL, lsiu_pkg::OP_LSR, lsiu_pkg::OP_ROL, lsiu_pkg::OP_ROR: begin
					if (a == lsiu_pkg::AM_ACC) begin
						acc = shift(m, acc);
					end else begin
						r.write_value = shift(m, opnd);
						r.write_enable = 1'b1;
					end
				end
				lsiu_pkg::OP_SLO: begin
					r.write_value = shift(lsiu_pkg::OP_ASL, opnd);
					r.write_enable = 1'b1;
					acc = acc | r.write_value;
					set_nz(acc);
				end
				lsiu_pkg::OP_RLA: begin
					r.write_value = shift(lsiu_pkg::OP_ROL, opnd);
					r.write_enable = 1'b1;
					acc = acc & r.write_value;
					set_nz(acc);
				end
				lsiu_pkg::OP_SRE: begin
					r.write_value = shift(lsiu_pkg::OP_LSR, opnd);
					r.write_enable = 1'b1;
					acc = acc ^ r.write_value;
					set_nz(acc);
				end
				lsiu_pkg::OP_SAX: begin
					r.write_value = acc & xv;
					r.write_enable = 1'b1;
				end
				default: begin
					z = ((acc & opnd) == 8'h00);
					v = opnd[6];
					n = opnd[7];
				end
			endcase
			r.handled = 1'b1;
			r.instr_length = t[5:4];
			r.cycle_count = t[3:0];
		end
		r.acc = acc;
		r.neg = n;
		r.zero = z;
		r.carry = c;
		r.ovf = v;
		exec_results.push_back(r);
	endfunction

	function void compare(string field, logic [7:0] want, logic [7:0] got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endfunction

	function void retire(exec_result_t got);
		exec_result_t want;
		if (exec_results.size() == 0) begin
			$error("result with no item pending");
			mismatches++;
			return;
		end
		want = exec_results.pop_front();
		compare("handled", 8'(want.handled), 8'(got.handled));
		compare("write_enable", 8'(want.write_enable), 8'(got.write_enable));
		compare("write_value", want.write_value, got.write_value);
		compare("instr_length", 8'(want.instr_length), 8'(got.instr_length));
		compare("cycle_count", 8'(want.cycle_count), 8'(got.cycle_count));
		compare("acc_out", want.acc, got.acc);
		compare("neg_out", 8'(want.neg), 8'(got.neg));
		compare("zero_out", 8'(want.zero), 8'(got.zero));
		compare("carry_out", 8'(want.carry), 8'(got.carry));
		compare("overflow_out", 8'(want.ovf), 8'(got.ovf));
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 150;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [3:0] mode = '0;
	logic [3:0] addressing = '0;
	logic [7:0] operand = '0;
	logic [7:0] x_value = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       handled;
	logic       write_enable;
	logic [7:0] write_value;
	logic [1:0] instr_length;
	logic [3:0] cycle_count;
	logic [7:0] acc_out;
	logic       neg_out;
	logic       zero_out;
	logic       carry_out;
	logic       overflow_out;

	logic quiet = 1'b0;
	int   burst_left = 0;
	int   hold_req = 0;
	int   hold_done = 0;

	exec_predict predict = new();

	logic_shift_instruction_unit uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 50);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				predict.retire({handled, write_enable, write_value, instr_length, cycle_count,
					acc_out, neg_out, zero_out, carry_out, overflow_out});
			if (in_valid && !in_stall)
				predict.issue(mode, addressing, operand, x_value);
		end
	end

	// result side
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = quiet ? 0 : gap_len();
			end
		end
	end

	task automatic drive_item(input logic [3:0] m, input logic [3:0] a,
			input logic [7:0] o, input logic [7:0] xv);
		int g;
		mode <= m;
		addressing <= a;
		operand <= o;
		x_value <= xv;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		g = (quiet || burst_left > 0) ? 0 : gap_len();
		if (burst_left > 0)
			burst_left--;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (predict.exec_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [3:0] m;
		logic [3:0] a;
		logic [7:0] o;
		@(posedge arst_n);
		@(posedge clk);

		drive_item(lsiu_pkg::OP_ORA, lsiu_pkg::AM_IMM, 8'h00, 8'h00);
		drive_item(lsiu_pkg::OP_ORA, lsiu_pkg::AM_IMM, 8'h80, 8'hFF);
		drive_item(lsiu_pkg::OP_ASL, lsiu_pkg::AM_ACC, 8'h00, 8'h00);
		drive_item(lsiu_pkg::OP_ROL, lsiu_pkg::AM_ACC, 8'hFF, 8'hFF);
		drive_item(lsiu_pkg::OP_EOR, lsiu_pkg::AM_IMM, 8'hFF, 8'h00);
		drive_item(lsiu_pkg::OP_ROR, lsiu_pkg::AM_ACC, 8'h00, 8'h00);
		drive_item(lsiu_pkg::OP_LSR, lsiu_pkg::AM_ZP, 8'h01, 8'hFF);
		drive_item(lsiu_pkg::OP_ROR, lsiu_pkg::AM_ZP, 8'h00, 8'h00);
		drive_item(lsiu_pkg::OP_LSR, lsiu_pkg::AM_ABS, 8'hFF, 8'h00);
		drive_item(lsiu_pkg::OP_ASL, lsiu_pkg::AM_ABSX, 8'h80, 8'hFF);
		drive_item(lsiu_pkg::OP_ROL, lsiu_pkg::AM_ZPX, 8'hFF, 8'h00);
		drive_item(lsiu_pkg::OP_AND, lsiu_pkg::AM_ZP, 8'hFF, 8'h00);
		drive_item(lsiu_pkg::OP_BIT, lsiu_pkg::AM_ZP, 8'hC0, 8'h00);
		drive_item(lsiu_pkg::OP_BIT, lsiu_pkg::AM_ABS, 8'h00, 8'hFF);
		drive_item(lsiu_pkg::OP_SLO, lsiu_pkg::AM_INDY, 8'h80, 8'h00);
		drive_item(lsiu_pkg::OP_RLA, lsiu_pkg::AM_INDX, 8'hFF, 8'h00);
		drive_item(lsiu_pkg::OP_SRE, lsiu_pkg::AM_ABSY, 8'h01, 8'h00);
		drive_item(lsiu_pkg::OP_SAX, lsiu_pkg::AM_ZPY, 8'h00, 8'hFF);
		drive_item(lsiu_pkg::OP_SAX, lsiu_pkg::AM_INDX, 8'hFF, 8'h00);
		drive_item(lsiu_pkg::OP_SAX, lsiu_pkg::AM_ABS, 8'h55, 8'hAA);
		// unsupported pairings leave the state alone
		drive_item(4'd15, 4'd15, 8'hFF, 8'hFF);
		drive_item(4'd12, lsiu_pkg::AM_IMM, 8'h00, 8'h00);
		drive_item(lsiu_pkg::OP_AND, 4'd10, 8'hFF, 8'hFF);
		drive_item(lsiu_pkg::OP_SAX, lsiu_pkg::AM_ZPX, 8'hFF, 8'hFF);
		drive_item(lsiu_pkg::OP_BIT, lsiu_pkg::AM_IMM, 8'h80, 8'h00);
		drive_item(lsiu_pkg::OP_ORA, lsiu_pkg::AM_ACC, 8'hFF, 8'h00);

		for (int i = 0; i < 1950; i++) begin
			if (i == 400 || i == 1500) begin
				hold_req++;
				burst_left = 40;
			end
			if (i == 900 || i == 1700)
				drain();
			quiet = (i >= 1150 && i < 1300);
			if ($urandom_range(0, 9) < 8) begin
				do begin
					m = 4'($urandom_range(0, 11));
					a = 4'($urandom_range(0, 9));
				end while (predict.timing(m, a) == '0);
			end else begin
				m = 4'($urandom_range(0, 15));
				a = 4'($urandom_range(0, 15));
			end
			case ($urandom_range(0, 7))
				0: o = 8'h00;
				1: o = 8'hFF;
				2: o = 8'h80;
				3: o = 8'h01;
				default: o = 8'($urandom_range(0, 255));
			endcase
			drive_item(m, a, o, 8'($urandom_range(0, 255)));
		end

		drain();
		repeat (8) @(posedge clk);
		if (predict.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
